@@ hw/rtl/pgwh_pkg.sv @@
package pgwh_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LEN_W  = 32;
   localparam int unsigned MAX_W  = 31;
   localparam int unsigned POS_W  = 4;

   localparam logic [MAX_W-1:0] MAX_PACKET_RESET = 31'h7FFF_FFFF;

   // special header codes
   localparam logic [LEN_W-1:0] CODE_CANCEL     = 32'd80877102;
   localparam logic [LEN_W-1:0] CODE_SSLREQ     = 32'd80877103;
   localparam logic [LEN_W-1:0] CODE_STARTUP_V2 = 32'h0002_0000;
   localparam logic [15:0]      V3_MAJOR        = 16'd3;
   localparam logic [15:0]      V3_MINOR_LIMIT  = 16'd2;

   // smallest legal length: header size minus one
   localparam logic [LEN_W-1:0] MIN_LEN_NEW = 32'd4;
   localparam logic [LEN_W-1:0] MIN_LEN_OLD = 32'd7;

   // byte positions (count of header bytes seen so far)
   localparam logic [POS_W-1:0] POS_TYPE      = 4'd1;
   localparam logic [POS_W-1:0] POS_LEN_LAST  = 4'd4;
   localparam logic [POS_W-1:0] POS_OLD_LEN_A = 4'd2;
   localparam logic [POS_W-1:0] POS_OLD_LEN_B = 4'd3;
   localparam logic [POS_W-1:0] POS_CODE_LAST = 4'd7;
   localparam logic [POS_W-1:0] POS_NEW_DONE  = 4'd5;
   localparam logic [POS_W-1:0] POS_OLD_DONE  = 4'd8;
   localparam logic [POS_W-1:0] POS_MAX       = 4'd15;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_SHORT       = 3'd1,
      STATUS_BAD_SECOND  = 3'd2,
      STATUS_UNKNOWN     = 3'd3,
      STATUS_BAD_LENGTH  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      KIND_REGULAR    = 3'd0,
      KIND_CANCEL     = 3'd1,
      KIND_SSL_REQ    = 3'd2,
      KIND_STARTUP_V3 = 3'd3,
      KIND_STARTUP_V2 = 3'd4
   } kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              first;
      logic              last;
   } req_type;

   typedef struct packed {
      status_type        status;
      kind_type          kind;
      logic [BYTE_W-1:0] msg_type;
      logic [LEN_W-1:0]  msg_length;
      logic              new_format;
   } rsp_type;

   typedef struct packed {
      logic     known;
      kind_type kind;
   } code_class_type;

   function automatic code_class_type classify_code(input logic [LEN_W-1:0] code);
      code_class_type c;
      c.known = 1'b1;
      c.kind  = KIND_REGULAR;
      if (code == CODE_CANCEL) begin
         c.kind = KIND_CANCEL;
      end else if (code == CODE_SSLREQ) begin
         c.kind = KIND_SSL_REQ;
      end else if (code[31:16] == V3_MAJOR && code[15:0] < V3_MINOR_LIMIT) begin
         c.kind = KIND_STARTUP_V3;
      end else if (code == CODE_STARTUP_V2) begin
         c.kind = KIND_STARTUP_V2;
      end else begin
         c.known = 1'b0;
      end
      return c;
   endfunction

endpackage

@@ hw/rtl/pg_wire_header_classifier_unit.sv @@
// Frontend message header classifier. Bytes of a message enter one per req_
// transaction, with req_first marking the byte that opens a header and
// req_last marking the last byte currently in the buffer. A nonzero first
// byte opens a 5-byte header (type plus big-endian 32-bit length); a zero
// first byte opens an 8-byte special header (zero byte, zero second byte,
// 16-bit length, 32-bit code classified as cancel, ssl request, startup v3
// or v2). At most one rsp_ transaction is given per header, either when it
// completes or when it fails (short buffer, bad second byte, unknown code,
// length out of range against csr_max_packet_size); a header cut off by a
// new first byte gives none. Extra bytes are dropped until the next first
// byte. Throughput is one byte per clock while the result slot is free or
// draining: each byte passes an input register, the combinational parse
// logic and a result register that drives rsp_valid. The limit register
// resets to 2^31-1 and should be written only while no bytes are in flight.
module pg_wire_header_classifier_unit (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [pgwh_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic                           req_first,
   input  logic                           req_last,

   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [2:0]                     rsp_status,
   output logic [2:0]                     rsp_kind,
   output logic [pgwh_pkg::BYTE_W-1:0]    rsp_msg_type,
   output logic [pgwh_pkg::LEN_W-1:0]     rsp_msg_length,
   output logic                           rsp_new_format,

   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pgwh_pkg::MAX_W-1:0]     csr_max_packet_size
);

   // input stage
   logic              in_valid_ff, in_valid_in;
   pgwh_pkg::req_type in_ff,       in_in;

   // result stage
   logic              out_valid_ff, out_valid_in;
   pgwh_pkg::rsp_type out_ff,       out_in;

   // limit register
   logic [pgwh_pkg::MAX_W-1:0] max_ff, max_in;

   logic              advance;
   logic              parse_valid;
   pgwh_pkg::rsp_type parse_rsp;

   // the held byte moves through the parser when the result slot is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (req_valid && req_ready) begin
         in_valid_in     = 1'b1;
         in_in.data_byte = req_data_byte;
         in_in.first     = req_first;
         in_in.last      = req_last;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         // bytes that give no result leave the slot empty
         out_valid_in = parse_valid;
         if (parse_valid) begin
            out_in = parse_rsp;
         end
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign max_in = (csr_valid && csr_ready) ? csr_max_packet_size : max_ff;

   pgwh_parse u_parse (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .req             (in_ff),
      .max_packet_size (max_ff),
      .rsp_valid       (parse_valid),
      .rsp             (parse_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         max_ff       <= pgwh_pkg::MAX_PACKET_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         max_ff       <= max_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_status     = out_ff.status;
   assign rsp_kind       = out_ff.kind;
   assign rsp_msg_type   = out_ff.msg_type;
   assign rsp_msg_length = out_ff.msg_length;
   assign rsp_new_format = out_ff.new_format;

endmodule

@@ hw/rtl/pgwh_parse.sv @@
module pgwh_parse (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  pgwh_pkg::req_type                   req,
   input  logic [pgwh_pkg::MAX_W-1:0]          max_packet_size,
   output logic                                rsp_valid,
   output pgwh_pkg::rsp_type                   rsp
);

   logic [pgwh_pkg::POS_W-1:0]  pos_ff,  pos_in;
   logic                        old_ff,  old_in;
   logic [pgwh_pkg::LEN_W-1:0]  len_ff,  len_in;
   logic [pgwh_pkg::LEN_W-1:0]  code_ff, code_in;
   logic [pgwh_pkg::BYTE_W-1:0] type_ff, type_in;
   logic                        sbad_ff, sbad_in;
   logic                        done_ff, done_in;
   logic                        done_keep;
   logic                        active;
   logic [pgwh_pkg::LEN_W-1:0]  old_len;
   logic [pgwh_pkg::LEN_W-1:0]  max_ext;
   pgwh_pkg::code_class_type    cls;

   // header field accumulation
   always_comb begin
      pos_in    = pos_ff;
      old_in    = old_ff;
      len_in    = len_ff;
      code_in   = code_ff;
      type_in   = type_ff;
      sbad_in   = sbad_ff;
      done_keep = done_ff;
      active    = 1'b0;
      if (req.first) begin
         active    = 1'b1;
         pos_in    = pgwh_pkg::POS_TYPE;
         type_in   = req.data_byte;
         old_in    = (req.data_byte == '0);
         len_in    = '0;
         code_in   = '0;
         sbad_in   = 1'b0;
         done_keep = 1'b0;
      end else if (!done_ff) begin
         active = 1'b1;
         if (!old_ff) begin
            if (pos_ff >= pgwh_pkg::POS_TYPE && pos_ff <= pgwh_pkg::POS_LEN_LAST) begin
               len_in = {len_ff[pgwh_pkg::LEN_W-pgwh_pkg::BYTE_W-1:0], req.data_byte};
            end
         end else begin
            if (pos_ff == pgwh_pkg::POS_TYPE) begin
               sbad_in = (req.data_byte != '0);
            end else if (pos_ff == pgwh_pkg::POS_OLD_LEN_A ||
                         pos_ff == pgwh_pkg::POS_OLD_LEN_B) begin
               len_in = {len_ff[pgwh_pkg::LEN_W-pgwh_pkg::BYTE_W-1:0], req.data_byte};
            end else if (pos_ff >= pgwh_pkg::POS_LEN_LAST &&
                         pos_ff <= pgwh_pkg::POS_CODE_LAST) begin
               code_in = {code_ff[pgwh_pkg::LEN_W-pgwh_pkg::BYTE_W-1:0], req.data_byte};
            end
         end
         if (pos_ff != pgwh_pkg::POS_MAX) begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   assign cls     = pgwh_pkg::classify_code(code_in);
   assign old_len = {16'b0, len_in[15:0]};
   assign max_ext = {1'b0, max_packet_size};

   // result decision
   always_comb begin
      rsp_valid       = 1'b0;
      rsp.status      = pgwh_pkg::STATUS_OK;
      rsp.kind        = pgwh_pkg::KIND_REGULAR;
      rsp.msg_type    = '0;
      rsp.msg_length  = '0;
      rsp.new_format  = 1'b0;
      if (active) begin
         if (!old_in && pos_in == pgwh_pkg::POS_NEW_DONE) begin
            rsp_valid      = 1'b1;
            rsp.msg_type   = type_in;
            rsp.msg_length = len_in;
            rsp.new_format = 1'b1;
            if (len_in < pgwh_pkg::MIN_LEN_NEW || len_in > max_ext) begin
               rsp.status = pgwh_pkg::STATUS_BAD_LENGTH;
            end
         end else if (old_in && sbad_in && pos_in == pgwh_pkg::POS_NEW_DONE) begin
            rsp_valid  = 1'b1;
            rsp.status = pgwh_pkg::STATUS_BAD_SECOND;
         end else if (old_in && !sbad_in && pos_in == pgwh_pkg::POS_OLD_DONE) begin
            rsp_valid = 1'b1;
            if (!cls.known) begin
               rsp.status = pgwh_pkg::STATUS_UNKNOWN;
            end else begin
               rsp.kind       = cls.kind;
               rsp.msg_length = old_len;
               if (old_len < pgwh_pkg::MIN_LEN_OLD || old_len > max_ext) begin
                  rsp.status = pgwh_pkg::STATUS_BAD_LENGTH;
               end
            end
         end else if (req.last) begin
            rsp_valid  = 1'b1;
            rsp.status = pgwh_pkg::STATUS_SHORT;
         end
      end
   end

   assign done_in = rsp_valid ? 1'b1 : done_keep;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         old_ff  <= 1'b0;
         len_ff  <= '0;
         code_ff <= '0;
         type_ff <= '0;
         sbad_ff <= 1'b0;
         done_ff <= 1'b1;
      end else if (step) begin
         pos_ff  <= pos_in;
         old_ff  <= old_in;
         len_ff  <= len_in;
         code_ff <= code_in;
         type_ff <= type_in;
         sbad_ff <= sbad_in;
         done_ff <= done_in;
      end
   end

   a_result_needs_open_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (req.first || !done_ff))
      else $error("result from an idle parser");

   a_result_closes_header: assert property (@(posedge clock) disable iff (reset)
      step && rsp_valid |=> done_ff)
      else $error("header still open after its result");

   a_open_position_range: assert property (@(posedge clock) disable iff (reset)
      !done_ff |-> (pos_ff >= pgwh_pkg::POS_TYPE && pos_ff <= pgwh_pkg::POS_CODE_LAST))
      else $error("open header at impossible byte position");

   a_ok_length_in_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.status == pgwh_pkg::STATUS_OK |-> rsp.msg_length <= max_ext)
      else $error("ok result with length above limit");

endmodule
